>>> rtl/rwc_pkg.sv
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared constants, word types and the byte term function of the rolling
// weak checksum block.
// ----------------------------------------------------------------------------
package rwc_pkg;

	localparam int WINDOW_DEPTH = 4096;
	localparam int PTR_W        = $clog2(WINDOW_DEPTH);
	localparam int LEN_W        = PTR_W + 1;
	localparam int WL_W         = 13;
	localparam int OFS_W        = 8;
	localparam int BYTE_W       = 8;
	localparam int SUM_W        = 16;
	localparam int CFG_IDX_W    = 1;

	localparam logic [WL_W-1:0] WL_RESET = WL_W'(512);

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_ROLL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_BIAS     = 1'b1;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_START,
		OP_LOAD,
		OP_ROLL
	} sum_op_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] data_byte;
	} src_word_t;

	typedef struct packed {
		logic [2*SUM_W-1:0] checksum;
		logic               window_full;
		logic               rejected;
	} dst_word_t;

	typedef struct packed {
		sum_op_t          op;
		logic [SUM_W-1:0] term;
		logic [LEN_W-1:0] len;
		logic             full;
		logic             rejected;
	} stage_t;

	// signed byte plus signed offset, wrapped to the sum width
	function automatic logic [SUM_W-1:0] byte_term(input logic [BYTE_W-1:0] raw,
			input logic [OFS_W-1:0] ofs);
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] o;
		b = {{(SUM_W-BYTE_W){raw[BYTE_W-1]}}, raw};
		o = {{(SUM_W-OFS_W){ofs[OFS_W-1]}}, ofs};
		return b + o;
	endfunction

endpackage

>>> rtl/rolling_weak_checksum_top.sv
// ----------------------------------------------------------------------------
// rolling_weak_checksum_top
// Rolling weak checksum over a sliding byte window held in a ring RAM.
// ----------------------------------------------------------------------------
// Takes one word per clock unless a length write, pointer reduction or output
// stall holds it off; one result word per input word. A roll word costs one
// window RAM read and one write in the accept cycle (it reads the oldest byte
// and overwrites it at the same address); valid start and load words only
// write. The sum update follows in the second stage, where the dropped byte
// times the window length is subtracted from s2. Writing window_length blocks
// input words in its write cycle and the PTR_W serial pointer reduction
// steps; config writes are always accepted. The RAM is not cleared after reset.
module rolling_weak_checksum_top import rwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  src_word_t            src_data,
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output dst_word_t            dst_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WL_W-1:0]      cfg_data
);

	logic [WL_W-1:0]  window_length_q;
	logic [OFS_W-1:0] byte_bias_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_stored_q;
	logic [LEN_W-1:0] fill_q;

	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] fill_eff;
	logic [LEN_W:0]   pos_sum;
	logic [LEN_W-1:0] ptr_inc;
	logic [PTR_W-1:0] ptr_roll;

	logic             cfg_fire;
	logic             len_write;
	logic             src_fire;
	logic             can_take;

	logic             pm_busy;
	logic             pm_done;
	logic [PTR_W-1:0] pm_rem;

	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic             ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	logic [PTR_W-1:0] ptr_n;
	logic [LEN_W-1:0] fill_n;
	stage_t           stage_s0;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign len_write = cfg_fire && (cfg_index == REG_WINDOW_LENGTH);
	assign src_ready = can_take && !pm_busy && !len_write;
	assign src_fire  = src_valid && src_ready;

	always_comb begin
		if (window_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(window_length_q) > WINDOW_DEPTH) begin
			len_eff = LEN_W'(WINDOW_DEPTH);
		end else begin
			len_eff = LEN_W'(window_length_q);
		end
		fill_eff = (fill_q > len_eff) ? len_eff : fill_q;

		// load slot: (oldest + fill) wrapped once
		pos_sum = (LEN_W+1)'(ptr_q) + (LEN_W+1)'(fill_eff);
		if (pos_sum >= (LEN_W+1)'(len_eff)) begin
			pos_sum = pos_sum - (LEN_W+1)'(len_eff);
		end

		ptr_inc  = LEN_W'(ptr_q) + LEN_W'(1);
		ptr_roll = (ptr_inc >= len_eff) ? '0 : ptr_inc[PTR_W-1:0];
	end

	always_comb begin
		ram_we            = 1'b0;
		ram_re            = 1'b0;
		ram_waddr         = ptr_q;
		ptr_n             = ptr_q;
		fill_n            = fill_eff;
		stage_s0.op       = OP_HOLD;
		stage_s0.term     = byte_term(src_data.data_byte, byte_bias_q);
		stage_s0.len      = len_eff;
		stage_s0.rejected = 1'b1;
		stage_s0.full     = (fill_eff >= len_eff);
		unique case (src_data.kind)
			KIND_START: begin
				ram_we            = 1'b1;
				ram_waddr         = '0;
				ptr_n             = '0;
				fill_n            = LEN_W'(1);
				stage_s0.op       = OP_START;
				stage_s0.rejected = 1'b0;
				stage_s0.full     = (len_eff == LEN_W'(1));
			end
			KIND_LOAD: begin
				if (fill_eff < len_eff) begin
					ram_we            = 1'b1;
					ram_waddr         = pos_sum[PTR_W-1:0];
					fill_n            = fill_eff + LEN_W'(1);
					stage_s0.op       = OP_LOAD;
					stage_s0.rejected = 1'b0;
					stage_s0.full     = (fill_eff + LEN_W'(1) >= len_eff);
				end
			end
			KIND_ROLL: begin
				if (fill_eff >= len_eff) begin
					ram_we            = 1'b1;
					ram_re            = 1'b1;
					ptr_n             = ptr_roll;
					stage_s0.op       = OP_ROLL;
					stage_s0.rejected = 1'b0;
					stage_s0.full     = 1'b1;
				end
			end
			default: begin
				stage_s0.op = OP_HOLD;
			end
		endcase
	end

	// ptr_stored_q keeps the pointer as the last word left it; every length
	// write reduces that value, so back-to-back length writes do not compound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WL_RESET;
			byte_bias_q     <= '0;
			ptr_q           <= '0;
			ptr_stored_q    <= '0;
			fill_q          <= '0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH: window_length_q <= cfg_data;
					REG_BYTE_BIAS:     byte_bias_q     <= cfg_data[OFS_W-1:0];
					default:           window_length_q <= window_length_q;
				endcase
			end
			if (src_fire) begin
				ptr_q        <= ptr_n;
				ptr_stored_q <= ptr_n;
				fill_q       <= fill_n;
			end else if (pm_done && !len_write) begin
				ptr_q <= pm_rem;
			end
		end
	end

	rwc_ptr_mod u_ptr_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (len_write),
		.ptr_in (ptr_stored_q),
		.len    (len_eff),
		.busy   (pm_busy),
		.done   (pm_done),
		.rem    (pm_rem)
	);

	rwc_window_ram u_window_ram (
		.clk   (clk),
		.we    (src_fire && ram_we),
		.waddr (ram_waddr),
		.wdata (src_data.data_byte),
		.re    (src_fire && ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	rwc_sum_unit u_sum_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (src_fire),
		.stage_in  (stage_s0),
		.rd_data   (ram_rdata),
		.byte_bias (byte_bias_q),
		.can_take  (can_take),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	a_no_accept_while_reducing: assert property (@(posedge clk) disable iff (!arst_n)
		src_fire |-> !pm_busy)
		else $error("word accepted during pointer reduction");

	a_ptr_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		!pm_busy |-> LEN_W'(ptr_q) < len_eff)
		else $error("oldest pointer outside window");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		src_fire |=> fill_q <= $past(len_eff))
		else $error("fill count grew past window length");

endmodule

>>> rtl/rwc_window_ram.sv
// ----------------------------------------------------------------------------
// rwc_window_ram
// Window byte store: one write port, one registered read port, read-first.
// ----------------------------------------------------------------------------
module rwc_window_ram import rwc_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [PTR_W-1:0]  waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [PTR_W-1:0]  raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [WINDOW_DEPTH];

	// same-address read and write returns the old byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/rwc_ptr_mod.sv
// ----------------------------------------------------------------------------
// rwc_ptr_mod
// Serial remainder unit: reduces the oldest pointer modulo a new window
// length, one pointer bit per cycle (restoring division).
// ----------------------------------------------------------------------------
module rwc_ptr_mod import rwc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PTR_W-1:0] ptr_in,
	input  logic [LEN_W-1:0] len,
	output logic             busy,
	output logic             done,
	output logic [PTR_W-1:0] rem
);

	localparam int CNT_W = $clog2(PTR_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] shreg_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W-1:0] rem_next;
	logic             last;

	always_comb begin
		trial = {rem_q, shreg_q[PTR_W-1]};
		if (trial >= (LEN_W+1)'(len)) begin
			rem_next = LEN_W'(trial - (LEN_W+1)'(len));
		end else begin
			rem_next = LEN_W'(trial);
		end
		last = (cnt_q == CNT_W'(PTR_W - 1));
	end

	assign busy = busy_q;
	assign done = busy_q && last;
	assign rem  = rem_next[PTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= ptr_in;
			rem_q   <= '0;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[PTR_W-2:0], 1'b0};
			rem_q   <= rem_next;
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("remainder unit not busy after start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && !start |=> !busy_q)
		else $error("remainder unit still busy after last step");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < len)
		else $error("partial remainder not below window length");

endmodule

>>> rtl/rwc_sum_unit.sv
// ----------------------------------------------------------------------------
// rwc_sum_unit
// Second stage: running sums s1/s2 updated with each new byte term and, on a
// roll, the byte dropped from the window, plus the output word register.
// ----------------------------------------------------------------------------
module rwc_sum_unit import rwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  stage_t            stage_in,
	input  logic [BYTE_W-1:0] rd_data,
	input  logic [OFS_W-1:0]  byte_bias,
	output logic              can_take,
	output logic              dst_valid,
	input  logic              dst_ready,
	output dst_word_t         dst_data
);

	logic             v_s1;
	stage_t           stage_s1;
	logic [SUM_W-1:0] sum_low_q;
	logic [SUM_W-1:0] sum_high_q;
	logic             out_valid_q;
	dst_word_t        out_q;

	logic [SUM_W-1:0] old_term;
	logic [SUM_W-1:0] len16;
	logic [SUM_W-1:0] drop;
	logic [SUM_W-1:0] lo_n;
	logic [SUM_W-1:0] hi_n;
	logic             adv;

	always_comb begin
		old_term = byte_term(rd_data, byte_bias);
		len16    = SUM_W'(stage_s1.len);
		drop     = len16 * old_term;
		lo_n     = sum_low_q;
		hi_n     = sum_high_q;
		case (stage_s1.op)
			OP_START: begin
				lo_n = stage_s1.term;
				hi_n = stage_s1.term;
			end
			OP_LOAD: begin
				lo_n = sum_low_q + stage_s1.term;
				hi_n = sum_high_q + lo_n;
			end
			OP_ROLL: begin
				lo_n = sum_low_q + stage_s1.term - old_term;
				hi_n = sum_high_q + lo_n - drop;
			end
			default: begin
				lo_n = sum_low_q;
				hi_n = sum_high_q;
			end
		endcase
	end

	assign adv       = v_s1 && (!out_valid_q || dst_ready);
	assign can_take  = !v_s1 || adv;
	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			sum_low_q   <= '0;
			sum_high_q  <= '0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				sum_low_q   <= lo_n;
				sum_high_q  <= hi_n;
			end else if (dst_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stage_s1 <= stage_in;
		end
		if (adv) begin
			out_q.checksum    <= {hi_n, lo_n};
			out_q.window_full <= stage_s1.full;
			out_q.rejected    <= stage_s1.rejected;
		end
	end

	a_hold_keeps_sums: assert property (@(posedge clk) disable iff (!arst_n)
		adv && stage_s1.op == OP_HOLD |=> $stable(sum_low_q) && $stable(sum_high_q))
		else $error("rejected word changed the sums");

	a_adv_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("finished word not presented");

	a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(sum_low_q) && $stable(sum_high_q))
		else $error("stalled stage lost or updated");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bytes into the rolling weak checksum block and compares every result
// word with the running sums kept here, or with a fixed word on checked script
// rows. A short scripted pass covers reset state, byte extremes, rejected kinds
// and window length edge values. Random passes with well-formed start/load/roll
// runs and some noise follow, under three idle profiles, with one long output
// stall and a final run of loads with the length register above the depth.
// ----------------------------------------------------------------------------
module testbench;
	import rwc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STALL_LIMIT = 2000;
	localparam int          DRAIN_WAIT  = 4;
	localparam logic [1:0]  KIND_SPARE  = 2'd3;

	typedef enum logic [1:0] {
		ROW_REG,
		ROW_WORD,
		ROW_CHECKED
	} row_kind_t;

	typedef struct packed {
		row_kind_t             what;
		logic [CFG_IDX_W-1:0]  idx;
		logic [WL_W-1:0]       val;
		src_word_t             w;
		dst_word_t             want;
	} row_t;

	localparam int NUM_ROWS = 26;
	localparam row_t SCRIPT [NUM_ROWS] = '{
		'{ROW_CHECKED, REG_WINDOW_LENGTH, 13'd0, '{KIND_ROLL, 8'h55}, '{32'h0000_0000, 1'b0, 1'b1}},
		'{ROW_CHECKED, REG_WINDOW_LENGTH, 13'd0, '{KIND_SPARE, 8'hAA}, '{32'h0000_0000, 1'b0, 1'b1}},
		'{ROW_CHECKED, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h01}, '{32'h0001_0001, 1'b0, 1'b0}},
		'{ROW_CHECKED, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h80}, '{32'hFF82_FF81, 1'b0, 1'b0}},
		'{ROW_REG, REG_WINDOW_LENGTH, 13'd0, '{KIND_START, 8'h00}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_ROLL, 8'h7F}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h00}, '0},
		'{ROW_REG, REG_BYTE_BIAS, 13'h007F, '{KIND_START, 8'h00}, '0},
		'{ROW_CHECKED, REG_WINDOW_LENGTH, 13'd0, '{KIND_START, 8'h7F}, '{32'h00FE_00FE, 1'b1, 1'b0}},
		'{ROW_REG, REG_BYTE_BIAS, 13'h1F80, '{KIND_START, 8'h00}, '0},
		'{ROW_CHECKED, REG_WINDOW_LENGTH, 13'd0, '{KIND_START, 8'h80}, '{32'hFF00_FF00, 1'b1, 1'b0}},
		'{ROW_REG, REG_WINDOW_LENGTH, 13'd4096, '{KIND_START, 8'h00}, '0},
		'{ROW_CHECKED, REG_WINDOW_LENGTH, 13'd0, '{KIND_ROLL, 8'hFF}, '{32'hFF00_FF00, 1'b0, 1'b1}},
		'{ROW_REG, REG_WINDOW_LENGTH, 13'd3, '{KIND_START, 8'h00}, '0},
		'{ROW_REG, REG_BYTE_BIAS, 13'h0000, '{KIND_START, 8'h00}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_START, 8'hFF}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h7F}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h80}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h01}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_ROLL, 8'h00}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_ROLL, 8'hFF}, '0},
		// grow the window mid-run: loads wrap behind the oldest byte
		'{ROW_REG, REG_WINDOW_LENGTH, 13'd5, '{KIND_START, 8'h00}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h10}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_LOAD, 8'h20}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_ROLL, 8'h33}, '0},
		'{ROW_WORD, REG_WINDOW_LENGTH, 13'd0, '{KIND_SPARE, 8'hC3}, '0}
	};

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 src_valid = 1'b0;
	logic                 src_ready;
	src_word_t            src_data  = '0;
	logic                 dst_valid;
	logic                 dst_ready = 1'b0;
	dst_word_t            dst_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WL_W-1:0]      cfg_data  = '0;

	// checksum state mirrored from accepted words
	logic [BYTE_W-1:0] win_bytes   [WINDOW_DEPTH];
	bit                win_written [WINDOW_DEPTH];
	int unsigned       win_oldest = 0;
	int unsigned       win_fill   = 0;
	logic [SUM_W-1:0]  sum_a      = '0;
	logic [SUM_W-1:0]  sum_b      = '0;
	logic [WL_W-1:0]   cur_len    = WL_RESET;
	logic [OFS_W-1:0]  cur_ofs    = '0;

	dst_word_t pending_sums [$];
	int        mismatches   = 0;
	int        src_idle_pct = 0;
	int        dst_idle_pct = 0;
	bit        hold_req     = 1'b0;

	rolling_weak_checksum_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned eff_len();
		if (cur_len == 0) return 1;
		if (cur_len > WINDOW_DEPTH) return WINDOW_DEPTH;
		return cur_len;
	endfunction

	function automatic logic [SUM_W-1:0] byte_value(input logic [BYTE_W-1:0] raw);
		return SUM_W'(int'($signed(raw)) + int'($signed(cur_ofs)));
	endfunction

	// advance the sums by one accepted word and return the result it yields
	function automatic dst_word_t csum_advance(input src_word_t w);
		int unsigned      len;
		int unsigned      pos;
		logic [SUM_W-1:0] t_new;
		logic [SUM_W-1:0] t_old;
		logic [31:0]      prod;
		dst_word_t        r;
		len = eff_len();
		if (win_oldest >= len) win_oldest = win_oldest % len;
		if (win_fill > len) win_fill = len;
		t_new = byte_value(w.data_byte);
		r.rejected = 1'b0;
		case (w.kind)
			KIND_START: begin
				win_oldest = 0;
				win_bytes[0] = w.data_byte;
				win_written[0] = 1'b1;
				win_fill = 1;
				sum_a = t_new;
				sum_b = t_new;
			end
			KIND_LOAD: begin
				if (win_fill >= len) begin
					r.rejected = 1'b1;
				end else begin
					pos = win_oldest + win_fill;
					if (pos >= len) pos -= len;
					win_bytes[pos] = w.data_byte;
					win_written[pos] = 1'b1;
					win_fill++;
					sum_a = sum_a + t_new;
					sum_b = sum_b + sum_a;
				end
			end
			KIND_ROLL: begin
				if (win_fill < len) begin
					r.rejected = 1'b1;
				end else begin
					t_old = byte_value(win_bytes[win_oldest]);
					win_bytes[win_oldest] = w.data_byte;
					win_oldest++;
					if (win_oldest >= len) win_oldest = 0;
					prod = 32'(len) * 32'(t_old);
					sum_a = sum_a + t_new - t_old;
					sum_b = sum_b + sum_a - prod[SUM_W-1:0];
				end
			end
			default: begin
				r.rejected = 1'b1;
			end
		endcase
		r.checksum = {sum_b, sum_a};
		r.window_full = (win_fill >= len);
		return r;
	endfunction

	// mostly well-formed start/load/roll runs; noise_pct of the words are
	// restarts or arbitrary kinds
	function automatic src_word_t pick_word(input int noise_pct);
		int unsigned len;
		int unsigned fill;
		int          r;
		src_word_t   w;
		len = eff_len();
		fill = (win_fill > len) ? len : win_fill;
		r = $urandom_range(0, 99);
		if (r < noise_pct / 2) w.kind = 2'($urandom_range(0, 3));
		else if (r < noise_pct) w.kind = KIND_START;
		else w.kind = (fill < len) ? KIND_LOAD : KIND_ROLL;
		// never drop a byte slot that was not written since reset
		if (w.kind == KIND_ROLL && fill >= len && !win_written[win_oldest % len])
			w.kind = KIND_START;
		case ($urandom_range(0, 9))
			0: w.data_byte = 8'h00;
			1: w.data_byte = 8'h7F;
			2: w.data_byte = 8'h80;
			3: w.data_byte = 8'hFF;
			default: w.data_byte = 8'($urandom_range(0, 255));
		endcase
		return w;
	endfunction

	task automatic send_word(input src_word_t w, input bit has_want, input dst_word_t want);
		dst_word_t pred;
		src_data <= w;
		src_valid <= 1'b1;
		do @(posedge clk); while (!src_ready);
		pred = csum_advance(w);
		pending_sums.push_back(has_want ? want : pred);
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WL_W-1:0] val);
		wait_drained();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WINDOW_LENGTH) cur_len = val;
		else cur_ofs = val[OFS_W-1:0];
	endtask

	task automatic run_segment(input int n_words, input int noise_pct);
		for (int i = 0; i < n_words; i++) begin
			// each idle cycle is drawn on its own
			while ($urandom_range(0, 99) < src_idle_pct) begin
				src_valid <= 1'b0;
				@(posedge clk);
			end
			send_word(pick_word(noise_pct), 1'b0, '0);
		end
	endtask

	task automatic new_settings();
		logic [WL_W-1:0]  len;
		logic [OFS_W-1:0] ofs;
		int               which;
		case ($urandom_range(0, 9))
			0: len = 13'd0;
			1: len = 13'd1;
			2, 3: len = WL_W'($urandom_range(13, 64));
			default: len = WL_W'($urandom_range(2, 12));
		endcase
		case ($urandom_range(0, 9))
			0: ofs = 8'h80;
			1: ofs = 8'h7F;
			2: ofs = 8'h00;
			default: ofs = 8'($urandom_range(0, 255));
		endcase
		which = $urandom_range(0, 9);
		if (which < 7) write_reg(REG_WINDOW_LENGTH, len);
		// upper data bits are don't-care for the offset register
		if (which >= 3) write_reg(REG_BYTE_BIAS, {5'($urandom_range(0, 31)), ofs});
	endtask

	// output side: random backpressure plus one long hold on request
	initial begin : sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				dst_ready <= 1'b0;
			end else begin
				dst_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
			end
		end
	end

	initial begin : result_check
		dst_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && dst_valid && dst_ready) begin
				if (pending_sums.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word %h", $time, dst_data);
				end else begin
					want = pending_sums.pop_front();
					if (dst_data.checksum !== want.checksum) begin
						mismatches++;
						$display("%0t: checksum expected %h got %h", $time,
							want.checksum, dst_data.checksum);
					end
					if (dst_data.window_full !== want.window_full) begin
						mismatches++;
						$display("%0t: window_full expected %b got %b", $time,
							want.window_full, dst_data.window_full);
					end
					if (dst_data.rejected !== want.rejected) begin
						mismatches++;
						$display("%0t: rejected expected %b got %b", $time,
							want.rejected, dst_data.rejected);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((src_valid && src_ready) || (dst_valid && dst_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin : stimulus
		row_t row;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			win_bytes[i] = '0;
			win_written[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = SCRIPT[i];
			case (row.what)
				ROW_REG:     write_reg(row.idx, row.val);
				ROW_WORD:    send_word(row.w, 1'b0, '0);
				ROW_CHECKED: send_word(row.w, 1'b1, row.want);
				default:     ;
			endcase
		end

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 66 : 0;
			dst_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 29 : 0;
			for (int seg = 0; seg < 8; seg++) begin
				new_settings();
				if (ph == 2 && seg == 0) hold_req = 1'b1;
				if ($urandom_range(0, 1)) send_word(pick_word(100), 1'b0, '0);
				run_segment($urandom_range(50, 110), 10);
			end
		end

		// length register above the depth: a run of loads into the clamped window
		write_reg(REG_WINDOW_LENGTH, 13'd8191);
		write_reg(REG_BYTE_BIAS, 13'h0003);
		send_word('{KIND_START, 8'h9C}, 1'b0, '0);
		run_segment(48, 0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_sums.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
